// ----- design/jsu_pkg.sv -----
// Types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

   localparam int QueueDepth = 8;
   localparam int MaxBurst   = 4;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   localparam logic [7:0] CTL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTL_RETURN    = 8'h0D;
   localparam logic [7:0] CTL_TAB       = 8'h09;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam logic [20:0] ONE_BYTE_MAX   = 21'h7F;
   localparam logic [20:0] TWO_BYTE_MAX   = 21'h7FF;
   localparam logic [20:0] THREE_BYTE_MAX = 21'hFFFF;

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_ESCAPE,
      PH_HEX1,
      PH_PAIR_BS,
      PH_PAIR_U,
      PH_HEX2,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_done;
      logic       failed;
   } entry_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } utf8_type;

   function automatic hex_type hex_decode(logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.val = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic utf8_type utf8_encode(logic [20:0] cp);
      utf8_type u;
      u.bytes = '0;
      if (cp <= ONE_BYTE_MAX) begin
         u.count    = 3'd1;
         u.bytes[0] = cp[7:0];
      end else if (cp <= TWO_BYTE_MAX) begin
         u.count    = 3'd2;
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= THREE_BYTE_MAX) begin
         u.count    = 3'd3;
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         u.count    = 3'd4;
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

endpackage

// ----- design/json_string_unescape_utf8.sv -----
// Results of an item are written into the output queue when the item is accepted. One item is
// taken per cycle while req_ready is high; an item makes 0 to 4 results, which wait in an
// 8-entry output queue that drains one result per cycle while rsp_ready is high, and req_ready
// is high while that queue holds at most 4 results, so a burst of escape output always fits.
// Reset (synchronous, active high) returns the parser to plain text and empties the queue.
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_token_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_token_done,
   output logic       rsp_failed
);
   import jsu_pkg::*;

   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int IdxW = $clog2(MaxBurst);

   phase_type   phase_ff, phase_in;
   logic [1:0]  digits_ff, digits_in;
   logic [11:0] accum_ff, accum_in;
   logic [9:0]  high_ff, high_in;

   entry_type   queue_ff [QueueDepth];
   entry_type   queue_in [QueueDepth];
   logic [CntW-1:0] count_ff, count_in;

   entry_type   new_ent [MaxBurst];
   logic [2:0]  new_n;
   logic [2:0]  dec_n;
   hex_type     hex;
   logic [15:0] full_code;
   logic [20:0] cp;
   utf8_type    enc;
   logic        take, pop;
   logic [CntW-1:0] level;
   logic [CntW-1:0] off;

   assign take = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= CntW'(QueueDepth - MaxBurst));

   assign hex       = hex_decode(req_in_byte);
   assign full_code = {accum_ff, hex.val};

   // The low half of a pair is known to lie in DC00..DFFF when this is used.
   always_comb begin
      if (phase_ff == PH_HEX2) begin
         cp = SUPPLEMENTARY_BASE + {1'b0, high_ff, full_code[9:0]};
      end else begin
         cp = {5'd0, full_code};
      end
   end

   assign enc = utf8_encode(cp);

   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      accum_in  = accum_ff;
      high_in   = high_ff;
      dec_n     = 3'd0;
      for (int k = 0; k < MaxBurst; k++) begin
         new_ent[k] = '{out_byte: enc.bytes[k], byte_valid: 1'b1,
                        token_done: 1'b0, failed: 1'b0};
      end

      case (phase_ff)
         PH_NORMAL: begin
            if (req_in_byte == CH_BACKSLASH) begin
               phase_in = PH_ESCAPE;
            end else begin
               dec_n = 3'd1;
               new_ent[0].out_byte = req_in_byte;
            end
         end
         PH_ESCAPE: begin
            phase_in = PH_NORMAL;
            dec_n    = 3'd1;
            case (req_in_byte)
               CH_QUOTE:     new_ent[0].out_byte = CH_QUOTE;
               CH_BACKSLASH: new_ent[0].out_byte = CH_BACKSLASH;
               CH_SLASH:     new_ent[0].out_byte = CH_SLASH;
               CH_LOWER_B:   new_ent[0].out_byte = CTL_BACKSPACE;
               CH_LOWER_F:   new_ent[0].out_byte = CTL_FORMFEED;
               CH_LOWER_N:   new_ent[0].out_byte = CTL_NEWLINE;
               CH_LOWER_R:   new_ent[0].out_byte = CTL_RETURN;
               CH_LOWER_T:   new_ent[0].out_byte = CTL_TAB;
               CH_LOWER_U: begin
                  phase_in  = PH_HEX1;
                  digits_in = 2'd0;
                  accum_in  = '0;
                  dec_n     = 3'd0;
               end
               default: begin
                  phase_in = PH_DISCARD;
                  dec_n    = 3'd0;
               end
            endcase
         end
         PH_HEX1, PH_HEX2: begin
            if (!hex.ok) begin
               phase_in = PH_DISCARD;
            end else if (digits_ff != 2'd3) begin
               accum_in  = {accum_ff[7:0], hex.val};
               digits_in = digits_ff + 2'd1;
            end else begin
               digits_in = 2'd0;
               if (phase_ff == PH_HEX1) begin
                  if (full_code >= HIGH_SURR_FIRST && full_code <= HIGH_SURR_LAST) begin
                     high_in  = full_code[9:0];
                     phase_in = PH_PAIR_BS;
                  end else if (full_code >= LOW_SURR_FIRST && full_code <= LOW_SURR_LAST) begin
                     phase_in = PH_DISCARD;
                  end else begin
                     phase_in = PH_NORMAL;
                     dec_n    = enc.count;
                  end
               end else begin
                  if (full_code < LOW_SURR_FIRST || full_code > LOW_SURR_LAST) begin
                     phase_in = PH_DISCARD;
                  end else begin
                     phase_in = PH_NORMAL;
                     dec_n    = enc.count;
                  end
               end
            end
         end
         PH_PAIR_BS: begin
            phase_in = (req_in_byte == CH_BACKSLASH) ? PH_PAIR_U : PH_DISCARD;
         end
         PH_PAIR_U: begin
            if (req_in_byte == CH_LOWER_U) begin
               phase_in  = PH_HEX2;
               digits_in = 2'd0;
               accum_in  = '0;
            end else begin
               phase_in = PH_DISCARD;
            end
         end
         default: begin
            phase_in = PH_DISCARD;
         end
      endcase

      new_n = dec_n;
      if (req_token_end) begin
         // A token that ends cleanly marks its last byte; anything else ends in one bare fail.
         if (phase_in == PH_NORMAL && dec_n != 3'd0) begin
            new_ent[IdxW'(dec_n - 3'd1)].token_done = 1'b1;
         end else begin
            new_n      = 3'd1;
            new_ent[0] = '{out_byte: 8'h00, byte_valid: 1'b0,
                           token_done: 1'b1, failed: 1'b1};
         end
         phase_in  = PH_NORMAL;
         digits_in = 2'd0;
         accum_in  = '0;
         high_in   = '0;
      end

      if (!take) begin
         phase_in  = phase_ff;
         digits_in = digits_ff;
         accum_in  = accum_ff;
         high_in   = high_ff;
         new_n     = 3'd0;
      end
   end

   // Output queue: the head sits in entry zero and the queue shifts down on each pop.
   assign level = count_ff - CntW'(pop);

   always_comb begin
      off = '0;
      for (int i = 0; i < QueueDepth; i++) begin
         if (pop && i < QueueDepth - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         off = CntW'(i) - level;
         if (CntW'(i) >= level && CntW'(i) < level + CntW'(new_n)) begin
            queue_in[i] = new_ent[off[IdxW-1:0]];
         end
      end
   end

   assign count_in = level + CntW'(new_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NORMAL;
         digits_ff <= 2'd0;
         accum_ff  <= '0;
         high_ff   <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         accum_ff  <= accum_in;
         high_ff   <= high_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   assign rsp_valid      = (count_ff != '0);
   assign rsp_out_byte   = queue_ff[0].out_byte;
   assign rsp_byte_valid = queue_ff[0].byte_valid;
   assign rsp_token_done = queue_ff[0].token_done;
   assign rsp_failed     = queue_ff[0].failed;

endmodule

// ----- bench/tb_json_string_unescape_utf8.sv -----
// Self-checking testbench for the streaming JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   localparam int StreamItems = 450;
   localparam int HoldCycles  = 80;
   localparam int HoldAfter   = 150;
   localparam int StallLimit  = 2000;
   localparam int TailCycles  = 20;

   typedef struct {
      logic [7:0] in_byte;
      logic       token_end;
      bit         drain_first;
   } raw_item_type;

   typedef enum {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_token_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_token_done;
   logic       rsp_failed;

   json_string_unescape_utf8 dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_token_end  (req_token_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_token_done (rsp_token_done),
      .rsp_failed     (rsp_failed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   raw_item_type raw_stream[$];
   entry_type    decoded_bytes[$];
   entry_type    step_results[$];
   logic [7:0]   tok_bytes[$];

   logic [7:0] simple_letters [8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOWER_B,
                                      CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T};

   // Decoder state kept by the predictor.
   phase_type   dec_phase = PH_NORMAL;
   logic [1:0]  dec_nibbles = '0;
   logic [15:0] dec_code = '0;
   logic [9:0]  dec_high = '0;

   int failures;
   int items_accepted;
   int results_checked;
   int tokens_seen;
   int tokens_failed;
   int wide_chars;
   int drain_pauses;
   bit timed_out;

   function automatic int hex_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
      return -1;
   endfunction

   function automatic void push_data(logic [7:0] b);
      entry_type e;
      e.out_byte   = b;
      e.byte_valid = 1'b1;
      e.token_done = 1'b0;
      e.failed     = 1'b0;
      step_results.insert(step_results.size(), e);
   endfunction

   function automatic void push_utf8(logic [20:0] cp);
      if (cp <= ONE_BYTE_MAX) begin
         push_data(cp[7:0]);
      end else if (cp <= TWO_BYTE_MAX) begin
         push_data({3'b110, cp[10:6]});
         push_data({2'b10, cp[5:0]});
      end else if (cp <= THREE_BYTE_MAX) begin
         push_data({4'b1110, cp[15:12]});
         push_data({2'b10, cp[11:6]});
         push_data({2'b10, cp[5:0]});
      end else begin
         push_data({5'b11110, cp[20:18]});
         push_data({2'b10, cp[17:12]});
         push_data({2'b10, cp[11:6]});
         push_data({2'b10, cp[5:0]});
      end
   endfunction

   // Advances the decoder by one raw byte and queues the bytes it must produce.
   function automatic void unescape_byte(logic [7:0] c, logic last);
      int v;
      entry_type bare;
      step_results = {};
      case (dec_phase)
         PH_NORMAL: begin
            if (c == CH_BACKSLASH) dec_phase = PH_ESCAPE;
            else push_data(c);
         end
         PH_ESCAPE: begin
            dec_phase = PH_NORMAL;
            case (c)
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: push_data(c);
               CH_LOWER_B: push_data(CTL_BACKSPACE);
               CH_LOWER_F: push_data(CTL_FORMFEED);
               CH_LOWER_N: push_data(CTL_NEWLINE);
               CH_LOWER_R: push_data(CTL_RETURN);
               CH_LOWER_T: push_data(CTL_TAB);
               CH_LOWER_U: begin
                  dec_phase   = PH_HEX1;
                  dec_nibbles = '0;
                  dec_code    = '0;
               end
               default: dec_phase = PH_DISCARD;
            endcase
         end
         PH_HEX1, PH_HEX2: begin
            v = hex_value(c);
            if (v < 0) begin
               dec_phase = PH_DISCARD;
            end else begin
               dec_code = {dec_code[11:0], 4'(v)};
               if (dec_nibbles != 2'd3) begin
                  dec_nibbles++;
               end else begin
                  dec_nibbles = '0;
                  if (dec_phase == PH_HEX1) begin
                     if (dec_code >= HIGH_SURR_FIRST && dec_code <= HIGH_SURR_LAST) begin
                        dec_high  = dec_code[9:0];
                        dec_code  = '0;
                        dec_phase = PH_PAIR_BS;
                     end else if (dec_code >= LOW_SURR_FIRST && dec_code <= LOW_SURR_LAST) begin
                        dec_phase = PH_DISCARD;
                     end else begin
                        dec_phase = PH_NORMAL;
                        push_utf8({5'd0, dec_code});
                     end
                  end else if (dec_code >= LOW_SURR_FIRST && dec_code <= LOW_SURR_LAST) begin
                     dec_phase = PH_NORMAL;
                     push_utf8(SUPPLEMENTARY_BASE + {1'b0, dec_high, dec_code[9:0]});
                     wide_chars++;
                  end else begin
                     dec_phase = PH_DISCARD;
                  end
               end
            end
         end
         PH_PAIR_BS: dec_phase = (c == CH_BACKSLASH) ? PH_PAIR_U : PH_DISCARD;
         PH_PAIR_U: begin
            if (c == CH_LOWER_U) begin
               dec_phase   = PH_HEX2;
               dec_nibbles = '0;
               dec_code    = '0;
            end else begin
               dec_phase = PH_DISCARD;
            end
         end
         default: dec_phase = PH_DISCARD;
      endcase
      if (last) begin
         tokens_seen++;
         if (dec_phase == PH_NORMAL && step_results.size() > 0) begin
            step_results[step_results.size() - 1].token_done = 1'b1;
         end else begin
            // A malformed token collapses to a single bare failure marker.
            bare.out_byte   = 8'h00;
            bare.byte_valid = 1'b0;
            bare.token_done = 1'b1;
            bare.failed     = 1'b1;
            step_results    = {bare};
            tokens_failed++;
         end
         dec_phase   = PH_NORMAL;
         dec_nibbles = '0;
         dec_code    = '0;
         dec_high    = '0;
      end
      foreach (step_results[i]) decoded_bytes.insert(decoded_bytes.size(), step_results[i]);
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         failures++;
         $error("%s: expected %0h, got %0h", field, want, got);
      end
   endfunction

   // Stimulus helpers; they append to the token under construction.
   function automatic void add_byte(logic [7:0] b);
      tok_bytes.insert(tok_bytes.size(), b);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
   endfunction

   function automatic void put_digits(int count);
      for (int i = 0; i < count; i++) add_byte(hex_char(4'($urandom_range(0, 15))));
   endfunction

   function automatic void put_escape_u(logic [15:0] val);
      add_byte(CH_BACKSLASH);
      add_byte(CH_LOWER_U);
      for (int i = 3; i >= 0; i--) add_byte(hex_char(val[i*4 +: 4]));
   endfunction

   function automatic void put_noise();
      int count;
      count = $urandom_range(0, 4);
      for (int i = 0; i < count; i++) add_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
      return b;
   endfunction

   function automatic logic [7:0] bad_letter();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOWER_B, CH_LOWER_F,
                       CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_LOWER_U});
      return b;
   endfunction

   function automatic logic [15:0] bmp_value();
      logic [15:0] edges [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range('h0000, 'h007F));
         1: return 16'($urandom_range('h0080, 'h07FF));
         2: return 16'($urandom_range('h0800, 'hD7FF));
         3: return 16'($urandom_range('hE000, 'hFFFF));
         default: return edges[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic logic [15:0] high_value();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? HIGH_SURR_LAST : HIGH_SURR_FIRST;
      return 16'($urandom_range('hD800, 'hDBFF));
   endfunction

   function automatic logic [15:0] low_value();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? LOW_SURR_LAST : LOW_SURR_FIRST;
      return 16'($urandom_range('hDC00, 'hDFFF));
   endfunction

   // Appends one kind of malformation; the token always ends after it.
   function automatic void put_fault();
      logic [7:0] b;
      case ($urandom_range(0, 6))
         0: begin
            add_byte(CH_BACKSLASH);
            add_byte(bad_letter());
            put_noise();
         end
         1: begin
            add_byte(CH_BACKSLASH);
            add_byte(CH_LOWER_U);
            put_digits($urandom_range(0, 3));
            add_byte(non_hex_byte());
            put_noise();
         end
         2: begin
            put_escape_u(low_value());
            put_noise();
         end
         3: begin
            put_escape_u(high_value());
            do b = 8'($urandom_range(0, 255)); while (b == CH_BACKSLASH);
            add_byte(b);
            put_noise();
         end
         4: begin
            put_escape_u(high_value());
            add_byte(CH_BACKSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CH_LOWER_U);
            add_byte(b);
            put_noise();
         end
         5: begin
            put_escape_u(high_value());
            case ($urandom_range(0, 2))
               0: put_escape_u(bmp_value());
               1: put_escape_u(high_value());
               default: begin
                  add_byte(CH_BACKSLASH);
                  add_byte(CH_LOWER_U);
                  put_digits($urandom_range(0, 3));
                  add_byte(non_hex_byte());
               end
            endcase
            put_noise();
         end
         default: begin
            // The token stops in the middle of an escape.
            case ($urandom_range(0, 4))
               0: add_byte(CH_BACKSLASH);
               1: begin
                  add_byte(CH_BACKSLASH);
                  add_byte(CH_LOWER_U);
                  put_digits($urandom_range(0, 3));
               end
               2: put_escape_u(high_value());
               3: begin
                  put_escape_u(high_value());
                  add_byte(CH_BACKSLASH);
               end
               default: begin
                  put_escape_u(high_value());
                  add_byte(CH_BACKSLASH);
                  add_byte(CH_LOWER_U);
                  put_digits($urandom_range(0, 3));
               end
            endcase
         end
      endcase
   endfunction

   function automatic void build_token();
      int segs;
      int kind;
      bit broken;
      logic [7:0] b;
      tok_bytes = {};
      segs      = $urandom_range(1, 8);
      broken    = 1'b0;
      for (int s = 0; s < segs && !broken; s++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            b = 8'($urandom_range(0, 255));
            add_byte(b);
            if (b == CH_BACKSLASH) add_byte(CH_BACKSLASH);
         end else if (kind < 52) begin
            add_byte(CH_BACKSLASH);
            add_byte(simple_letters[$urandom_range(0, 7)]);
         end else if (kind < 72) begin
            put_escape_u(bmp_value());
         end else if (kind < 84) begin
            put_escape_u(high_value());
            put_escape_u(low_value());
         end else begin
            put_fault();
            broken = 1'b1;
         end
      end
   endfunction

   function automatic void queue_token(bit drain);
      raw_item_type it;
      foreach (tok_bytes[i]) begin
         it.in_byte     = tok_bytes[i];
         it.token_end   = (i == tok_bytes.size() - 1);
         it.drain_first = drain && (i == 0);
         raw_stream.insert(raw_stream.size(), it);
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   raw_item_type next_item;
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_in_byte   <= 8'h00;
         req_token_end <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (raw_stream.size() == 0 ||
                      (raw_stream[0].drain_first && (req_valid || decoded_bytes.size() != 0))) begin
            req_valid <= 1'b0;
         end else begin
            next_item = raw_stream.pop_front();
            if (next_item.drain_first) drain_pauses++;
            req_valid     <= 1'b1;
            req_in_byte   <= next_item.in_byte;
            req_token_end <= next_item.token_end;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Monitor: checks results, predicts each accepted item and paces the receiver.
   entry_type   want;
   rx_mode_type rx_mode = RX_STEADY;
   int mode_cycles;
   int hold_left;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (decoded_bytes.size() == 0) begin
               failures++;
               $error("unexpected result: out_byte=%0h byte_valid=%b token_done=%b failed=%b",
                      rsp_out_byte, rsp_byte_valid, rsp_token_done, rsp_failed);
            end else begin
               want = decoded_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
               check_field("token_done", 8'(want.token_done), 8'(rsp_token_done));
               check_field("failed", 8'(want.failed), 8'(rsp_failed));
            end
         end
         if (req_valid && req_ready) begin
            items_accepted++;
            unescape_byte(req_in_byte, req_token_end);
         end
         // One long hold-off lets the output queue fill so that req_ready drops.
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && items_accepted >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_cycles == 0) begin
               rx_mode     = rx_mode_type'($urandom_range(0, 3));
               mode_cycles = $urandom_range(16, 64);
            end else begin
               mode_cycles--;
            end
            case (rx_mode)
               RX_STEADY:  rsp_ready <= 1'b1;
               RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
               RX_PATTERN: rsp_ready <= (mode_cycles % 4 != 0);
               default:    rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   int stuck_cycles;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StallLimit) begin
         timed_out <= 1'b1;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      // Directed tokens: byte extremes with a closing quote escape, code point zero,
      // a surrogate pair, a bad escape letter, and a token that ends on a backslash.
      tok_bytes = {8'h00, 8'hFF, CH_BACKSLASH, CH_QUOTE};
      queue_token(1'b0);
      tok_bytes = {};
      put_escape_u(16'h0000);
      queue_token(1'b0);
      tok_bytes = {};
      put_escape_u(16'hD83D);
      put_escape_u(16'hDE00);
      queue_token(1'b0);
      tok_bytes = {CH_BACKSLASH, 8'h71};
      queue_token(1'b0);
      tok_bytes = {CH_BACKSLASH};
      queue_token(1'b0);

      for (int t = 0; raw_stream.size() < StreamItems; t++) begin
         build_token();
         // Now and then the sender waits for the block to drain before a token.
         queue_token(t % 12 == 5);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && (raw_stream.size() != 0 || req_valid || decoded_bytes.size() != 0))
         @(posedge clock);
      if (timed_out) begin
         failures++;
         $error("no item moved for %0d cycles", StallLimit);
      end else begin
         repeat (TailCycles) @(posedge clock);
      end
      if (decoded_bytes.size() != 0) begin
         failures++;
         $error("%0d expected results never arrived", decoded_bytes.size());
      end

      $display("Fed %0d bytes in %0d tokens (%0d malformed); checked %0d results, %0d %s",
               items_accepted, tokens_seen, tokens_failed, results_checked, wide_chars,
               "four-byte chars.");
      $display("Receiver held off %0d cycles once; sender waited for a full drain %0d times.",
               HoldCycles, drain_pauses);
      if (failures == 0) begin
         $display("json_string_unescape_utf8: match");
      end else begin
         $display("json_string_unescape_utf8: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/jsu_pkg.sv
design/json_string_unescape_utf8.sv
bench/tb_json_string_unescape_utf8.sv
